// File: rtl/rppl_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the hit-term table for the RICH PID Poisson scorer.
// No dependencies.
package rppl_pkg;

  localparam int unsigned NUM_HYP    = 3;
  localparam int unsigned TABLE_BITS = 10;
  localparam int unsigned TBL_SIZE   = 1 << TABLE_BITS;
  localparam int unsigned LAMBDA_W   = 16;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned MISS_W     = LAMBDA_W - 2;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SERIES_N   = 24;

  localparam logic [ADDR_W-1:0] REG_DARK_COUNT = ADDR_W'(0);

  typedef logic [LAMBDA_W-1:0] lambda_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [SUM_W-1:0]    hit_tbl_t [TBL_SIZE];

  typedef struct packed {
    logic load;
    logic adv;
    logic hit;
    logic clear;
  } lane_ctrl_t;

  // floor(num / den) by restoring shift and subtract, used only while building the table
  function automatic logic [63:0] div_floor64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // -2*ln(1 - exp(-x)) at each bin center, Q24.8, fixed-point Q32 series.
  function automatic hit_tbl_t build_hit_table();
    hit_tbl_t    tbl;
    logic [63:0] one_q;
    logic [63:0] ln2;
    logic [63:0] x12;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] e;
    logic [63:0] m;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] acc;
    logic [63:0] nl;
    logic [63:0] v;
    logic [63:0] s;
    one_q = 64'd1 << 32;
    // ln 2 from the same atanh series
    m   = one_q >> 1;
    z   = div_floor64((one_q - m) << 32, one_q + m);
    z2  = (z * z) >> 32;
    p   = z;
    acc = z;
    for (int k = 3; k < 3 + 2 * SERIES_N; k += 2) begin
      p   = (p * z2) >> 32;
      acc = acc + p / 64'(k);
    end
    ln2 = acc << 1;
    for (int i = 0; i < TBL_SIZE; i++) begin
      x12  = (64'(i) << (16 - TABLE_BITS)) + (64'd1 << (15 - TABLE_BITS));
      y    = (x12 << 20) >> 4;
      term = one_q;
      pos  = one_q;
      neg  = 64'd0;
      for (int k = 1; k <= SERIES_N; k++) begin
        term = ((term * y) >> 32) / 64'(k);
        if ((k & 1) != 0) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      e = (pos > neg) ? pos - neg : 64'd0;
      if (e >= one_q) e = one_q - 64'd1;
      for (int r = 0; r < 4; r++) e = (e * e) >> 32;
      if (e >= one_q) e = one_q - 64'd1;
      m = one_q - e;
      s = 64'd0;
      for (int r = 0; r < 32; r++) begin
        if (m < (one_q >> 1)) begin
          m = m << 1;
          s = s + 64'd1;
        end
      end
      if (m >= one_q) begin
        nl = 64'd0;
      end else begin
        z   = div_floor64((one_q - m) << 32, one_q + m);
        z2  = (z * z) >> 32;
        p   = z;
        acc = z;
        for (int k = 3; k < 3 + 2 * SERIES_N; k += 2) begin
          p   = (p * z2) >> 32;
          acc = acc + p / 64'(k);
        end
        nl = acc << 1;
      end
      v = (s * ln2 + nl) << 1;
      v = (v + (64'd1 << 23)) >> 24;
      tbl[i] = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    end
    return tbl;
  endfunction

  localparam hit_tbl_t HIT_TABLE = build_hit_table();

endpackage

// File: rtl/rppl_cfg.sv
`timescale 1ns / 1ps
// APB-style register port holding the dark count.
// Depends on rppl_pkg.
module rppl_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rppl_pkg::ADDR_W-1:0] paddr,
  input  logic [rppl_pkg::DATA_W-1:0] pwdata,
  output logic [rppl_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output rppl_pkg::lambda_t           dark_count_o
);
  import rppl_pkg::*;

  lambda_t dark_q, dark_d;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_DARK_COUNT[ADDR_W-1:2]);

  always_comb begin
    dark_d = dark_q;
    if (wr_en) dark_d = pwdata[LAMBDA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_q <= '0;
    end else begin
      dark_q <= dark_d;
    end
  end

  assign prdata       = (paddr[ADDR_W-1:2] == REG_DARK_COUNT[ADDR_W-1:2]) ?
                        {{(DATA_W-LAMBDA_W){1'b0}}, dark_q} : '0;
  assign dark_count_o = dark_q;

endmodule

// File: rtl/rppl_lane.sv
`timescale 1ns / 1ps
// One hypothesis lane: lambda register, hit/miss term and saturating accumulator.
// Depends on rppl_pkg.
module rppl_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rppl_pkg::lane_ctrl_t ctrl_i,
  input  rppl_pkg::lambda_t    pdf_i,
  input  rppl_pkg::lambda_t    dark_count_i,
  output rppl_pkg::sum_t       sum_o
);
  import rppl_pkg::*;

  lambda_t              lambda_q, lambda_d;
  logic [LAMBDA_W:0]    lam_sum;
  logic [LAMBDA_W:0]    miss_rnd;
  logic [MISS_W-1:0]    miss_term;
  sum_t                 term;
  logic [SUM_W:0]       acc_sum;
  sum_t                 acc_q, acc_d, acc_next;

  // saturating lambda = pdf + dark
  assign lam_sum  = {1'b0, pdf_i} + {1'b0, dark_count_i};
  assign lambda_d = lam_sum[LAMBDA_W] ? '1 : lam_sum[LAMBDA_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) lambda_q <= lambda_d;
  end

  assign miss_rnd  = {1'b0, lambda_q} + (LAMBDA_W+1)'(4);
  assign miss_term = miss_rnd[LAMBDA_W:3];
  assign term      = ctrl_i.hit ? HIT_TABLE[lambda_q[LAMBDA_W-1 -: TABLE_BITS]]
                                : {{(SUM_W-MISS_W){1'b0}}, miss_term};

  assign acc_sum  = {1'b0, acc_q} + {1'b0, term};
  assign acc_next = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.adv) acc_d = ctrl_i.clear ? '0 : acc_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign sum_o = acc_next;

`ifndef NO_ASSERTIONS
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.adv && ctrl_i.clear |=> acc_q == '0)
    else $error("accumulator not cleared after last pixel");
  a_acc_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.adv && !ctrl_i.clear |=> acc_q >= $past(acc_q))
    else $error("accumulator decreased within an event");
`endif

endmodule

// File: rtl/rich_pid_poisson_loglike.sv
`timescale 1ns / 1ps
// Top level of the RICH PID Poisson scorer: input register, three lanes, result register.
// Depends on rppl_pkg, rppl_cfg and rppl_lane.

// Takes one pixel per cycle. A pixel request is registered with its lambda
// (pdf plus dark count, saturated), and when it advances each lane adds its
// hit-table or 2*lambda term to a saturating Q24.8 sum. The request marked
// tlast loads the three sums into the result register and clears them, so a
// result appears once its last pixel leaves the input register. Throughput is
// one pixel per cycle; it drops only while a finished result is held by
// m_axis_tready low and another last pixel waits behind it.
module rich_pid_poisson_loglike (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [47:0]                 s_axis_tdata,  // pdf_pion, pdf_kaon, pdf_proton
  input  logic                        s_axis_tuser,  // pixel_hit
  input  logic                        s_axis_tlast,  // last_pixel
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [95:0]                 m_axis_tdata,  // nll_pion, nll_kaon, nll_proton
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rppl_pkg::ADDR_W-1:0] paddr,
  input  logic [rppl_pkg::DATA_W-1:0] pwdata,
  output logic [rppl_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import rppl_pkg::*;

  lambda_t    dark_count;
  lane_ctrl_t ctrl;
  logic       s1_valid_q, s1_valid_d;
  logic       s1_hit_q, s1_last_q;
  logic       out_valid_q, out_valid_d;
  logic       s_accept, adv, out_free;
  sum_t       lane_sum [NUM_HYP];
  logic [NUM_HYP*SUM_W-1:0] out_data_q;

  rppl_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .dark_count_o (dark_count)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = s1_valid_q && (!s1_last_q || out_free);
  assign s_axis_tready = !s1_valid_q || adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign ctrl.load  = s_accept;
  assign ctrl.adv   = adv;
  assign ctrl.hit   = s1_hit_q;
  assign ctrl.clear = s1_last_q;

  for (genvar h = 0; h < NUM_HYP; h++) begin : g_lane
    rppl_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .pdf_i        (s_axis_tdata[h*LAMBDA_W +: LAMBDA_W]),
      .dark_count_i (dark_count),
      .sum_o        (lane_sum[h])
    );
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_accept) s1_valid_d = 1'b1;
    else if (adv) s1_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (adv && s1_last_q) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_hit_q  <= s_axis_tuser;
      s1_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_last_q) begin
      for (int h = 0; h < NUM_HYP; h++) out_data_q[h*SUM_W +: SUM_W] <= lane_sum[h];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv && s1_last_q))
    else $error("result raised without a last pixel");
  a_stall_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_last_q |-> adv)
    else $error("non-last pixel stalled");
  a_stall_needs_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled without output backpressure");
`endif

endmodule
